>>> rtl/core/sawl_pkg.sv
// Shared types, widths and codes for the slot allocator with waitlist.
package sawl_pkg;

	// Field widths fixed by the item format
	localparam int MODE_W   = 2;
	localparam int ID_W     = 11;
	localparam int WEIGHT_W = 16;
	localparam int SIDX_W   = 4;
	localparam int PRICE_W  = 16;
	localparam int CHARGE_W = 32;
	localparam int TOTAL_W  = 48;
	localparam int CFG_W    = 5;
	localparam int ENTRY_W  = WEIGHT_W + ID_W;

	// Defaults for the top-level parameters
	localparam int SLOT_COUNT_DEF = 16;
	localparam int WAIT_DEPTH_DEF = 16;

	// slots_in_use after reset
	localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = CFG_W'(16);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Input mode codes
	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD   = 2'd0,
		MODE_ARRIVE = 2'd1,
		MODE_DEPART = 2'd2
	} mode_t;

	// Classified operation handed to the back end
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_ARRIVE,
		OP_DEPART,
		OP_MISS
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_WAIT_FULL = 2'd2
	} status_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		BS_IDLE,
		BS_SCAN,
		BS_PICK,
		BS_WAITRD,
		BS_MUL,
		BS_ACC
	} bstate_t;

	typedef struct packed {
		op_t                 op;
		logic [ID_W-1:0]     id;
		logic [WEIGHT_W-1:0] weight;
		logic [SIDX_W-1:0]   slot_index;
		logic [PRICE_W-1:0]  price;
	} cmd_t;

	typedef struct packed {
		logic                granted;
		logic [SIDX_W-1:0]   granted_slot;
		logic [ID_W-1:0]     granted_id;
		logic [CHARGE_W-1:0] charge;
		logic [TOTAL_W-1:0]  total;
		logic                queued;
		status_t             status;
	} result_t;

	// Queue handshake between the front end and the command queue
	typedef struct packed {
		logic push;
		cmd_t cmd;
	} qwr_t;

endpackage

>>> rtl/core/sawl_front.sv
// Front end: accepts input items and classifies them into back-end commands.
module sawl_front #(
	parameter int SLOT_COUNT = sawl_pkg::SLOT_COUNT_DEF
) (
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sawl_pkg::MODE_W-1:0]   mode,
	input  logic [sawl_pkg::ID_W-1:0]     requester_id,
	input  logic [sawl_pkg::WEIGHT_W-1:0] requester_weight,
	input  logic [sawl_pkg::SIDX_W-1:0]   slot_index,
	input  logic [sawl_pkg::PRICE_W-1:0]  slot_price,
	input  logic                          q_full,
	output sawl_pkg::qwr_t                q_wr
);
	import sawl_pkg::*;

	logic id_zero;

	assign id_zero  = (requester_id == '0);
	assign in_stall = q_full;

	// Decode mode and screen out items that change nothing
	always_comb begin
		q_wr.push           = in_valid && !q_full;
		q_wr.cmd.id         = requester_id;
		q_wr.cmd.weight     = requester_weight;
		q_wr.cmd.slot_index = slot_index;
		q_wr.cmd.price      = slot_price;
		unique case (mode_t'(mode))
			MODE_LOAD: begin
				q_wr.cmd.op = (int'(slot_index) < SLOT_COUNT) ? OP_LOAD : OP_NOP;
			end
			MODE_ARRIVE: begin
				q_wr.cmd.op = id_zero ? OP_NOP : OP_ARRIVE;
			end
			MODE_DEPART: begin
				// id zero never holds a slot
				q_wr.cmd.op = id_zero ? OP_MISS : OP_DEPART;
			end
			default: begin
				q_wr.cmd.op = OP_NOP;
			end
		endcase
	end

endmodule

>>> rtl/core/sawl_queue.sv
// Short command queue between the front end and the back end.
module sawl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  sawl_pkg::qwr_t q_wr,
	output logic           q_full,
	input  logic           pop,
	output logic           rd_valid,
	output sawl_pkg::cmd_t rd_cmd
);
	import sawl_pkg::*;

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = entry_q[rd_ptr_q];
	assign do_push  = q_wr.push && !q_full;
	assign do_pop   = pop && rd_valid;

	// Pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= q_wr.cmd;
		end
	end

endmodule

>>> rtl/core/sawl_back.sv
// Back end: slot search, waitlist, price memory, charge and running total.
module sawl_back #(
	parameter int SLOT_COUNT = sawl_pkg::SLOT_COUNT_DEF,
	parameter int WAIT_DEPTH = sawl_pkg::WAIT_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [sawl_pkg::CFG_W-1:0] slots_in_use,
	input  logic                       q_valid,
	input  sawl_pkg::cmd_t             q_cmd,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output sawl_pkg::result_t          out_res
);
	import sawl_pkg::*;

	localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int PW = $clog2(WAIT_DEPTH);
	localparam int CW = $clog2(WAIT_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(WAIT_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(WAIT_DEPTH);

	bstate_t state_q, state_d;
	cmd_t    cmd_q;

	// Slot occupancy: one comparator per slot
	logic [ID_W-1:0]       occ_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] free_vec_q;
	logic [SLOT_COUNT-1:0] hit_vec_q;
	logic [SLOT_COUNT-1:0] use_vec_q;

	// Memories
	logic [PRICE_W-1:0] price_mem [SLOT_COUNT];
	logic [ENTRY_W-1:0] wait_mem [WAIT_DEPTH];
	logic [PRICE_W-1:0] price_rd_q;
	logic [ENTRY_W-1:0] wait_rd_q;

	// Waitlist pointers
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] count_q;

	// Working registers
	logic [SW-1:0]       slot_q;
	logic [ID_W-1:0]     gid_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [CHARGE_W-1:0] product_q;
	logic [TOTAL_W-1:0]  total_q;
	result_t             res_q;
	logic                out_valid_q;

	// Combinational
	logic [SLOT_COUNT-1:0]    pick_vec;
	logic [SW-1:0]            pick_idx;
	logic                     pick_found;
	logic [SW+SIDX_W-1:0]     sidx_wide;
	logic [SW+SIDX_W-1:0]     slot_wide;
	logic [TOTAL_W:0]         sum;
	logic [TOTAL_W-1:0]       total_next;
	logic                     occ_we;
	logic [SW-1:0]            occ_waddr;
	logic [ID_W-1:0]          occ_wdata;
	logic                     price_we;
	logic                     price_re;
	logic                     wait_we;
	logic                     wait_re;
	logic                     res_ld;
	result_t                  res_d;

	assign out_valid = out_valid_q;
	assign out_res   = res_q;
	assign sidx_wide = {{SW{1'b0}}, cmd_q.slot_index};
	assign slot_wide = {{SIDX_W{1'b0}}, slot_q};

	// Saturating accumulate of the registered product
	assign sum        = {1'b0, total_q} + (TOTAL_W + 1)'(product_q);
	assign total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

	// Lowest set bit of the registered search vector
	always_comb begin
		pick_vec = (cmd_q.op == OP_ARRIVE) ? free_vec_q : hit_vec_q;
		pick_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (pick_vec[i]) begin
				pick_idx = SW'(i);
			end
		end
		pick_found = |pick_vec;
	end

	// Sequencer: next state and strobes
	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		occ_we       = 1'b0;
		occ_waddr    = pick_idx;
		occ_wdata    = '0;
		price_we     = 1'b0;
		price_re     = 1'b0;
		wait_we      = 1'b0;
		wait_re      = 1'b0;
		res_ld       = 1'b0;
		res_d        = '0;
		res_d.total  = total_q;
		res_d.status = STAT_OK;
		unique case (state_q)
			BS_IDLE: begin
				if (q_valid && (!out_valid_q || !out_stall)) begin
					q_pop   = 1'b1;
					state_d = BS_SCAN;
				end
			end
			BS_SCAN: begin
				state_d = BS_PICK;
			end
			BS_PICK: begin
				state_d = BS_IDLE;
				unique case (cmd_q.op)
					OP_LOAD: begin
						price_we = 1'b1;
						res_ld   = 1'b1;
					end
					OP_ARRIVE: begin
						if (pick_found) begin
							occ_we    = 1'b1;
							occ_wdata = cmd_q.id;
							price_re  = 1'b1;
							state_d   = BS_MUL;
						end else if (count_q == CNT_FULL) begin
							res_ld       = 1'b1;
							res_d.status = STAT_WAIT_FULL;
						end else begin
							wait_we      = 1'b1;
							res_ld       = 1'b1;
							res_d.queued = 1'b1;
						end
					end
					OP_DEPART: begin
						if (!pick_found) begin
							res_ld       = 1'b1;
							res_d.status = STAT_NOT_FOUND;
						end else begin
							occ_we = 1'b1;
							// hand the freed slot to the waitlist head if it is usable
							if ((count_q != '0) && use_vec_q[pick_idx]) begin
								price_re = 1'b1;
								wait_re  = 1'b1;
								state_d  = BS_WAITRD;
							end else begin
								res_ld = 1'b1;
							end
						end
					end
					OP_MISS: begin
						res_ld       = 1'b1;
						res_d.status = STAT_NOT_FOUND;
					end
					default: begin
						res_ld = 1'b1;
					end
				endcase
			end
			BS_WAITRD: begin
				occ_we    = 1'b1;
				occ_waddr = slot_q;
				occ_wdata = wait_rd_q[ID_W-1:0];
				state_d   = BS_MUL;
			end
			BS_MUL: begin
				state_d = BS_ACC;
			end
			BS_ACC: begin
				res_ld             = 1'b1;
				res_d.granted      = 1'b1;
				res_d.granted_slot = slot_wide[SIDX_W-1:0];
				res_d.granted_id   = gid_q;
				res_d.charge       = product_q;
				res_d.total        = total_next;
				state_d            = BS_IDLE;
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				occ_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (occ_we) begin
				occ_q[occ_waddr] <= occ_wdata;
			end
			if (wait_we) begin
				tail_q  <= (tail_q == PTR_LAST) ? '0 : tail_q + PW'(1);
				count_q <= count_q + CW'(1);
			end else if (wait_re) begin
				head_q  <= (head_q == PTR_LAST) ? '0 : head_q + PW'(1);
				count_q <= count_q - CW'(1);
			end
			if (state_q == BS_ACC) begin
				total_q <= total_next;
			end
			if (res_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q    <= q_cmd;
			weight_q <= q_cmd.weight;
		end
		if (state_q == BS_SCAN) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				free_vec_q[i] <= (occ_q[i] == '0) && (i < int'(slots_in_use));
				hit_vec_q[i]  <= (occ_q[i] == cmd_q.id);
				use_vec_q[i]  <= (i < int'(slots_in_use));
			end
		end
		if (state_q == BS_PICK) begin
			slot_q <= pick_idx;
			gid_q  <= cmd_q.id;
		end
		if (state_q == BS_WAITRD) begin
			gid_q    <= wait_rd_q[ID_W-1:0];
			weight_q <= wait_rd_q[ENTRY_W-1:ID_W];
		end
		if (state_q == BS_MUL) begin
			product_q <= CHARGE_W'(price_rd_q) * CHARGE_W'(weight_q);
		end
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	// Price memory
	always_ff @(posedge clk) begin
		if (price_we) begin
			price_mem[sidx_wide[SW-1:0]] <= cmd_q.price;
		end
		if (price_re) begin
			price_rd_q <= price_mem[pick_idx];
		end
	end

	// Waitlist memory
	always_ff @(posedge clk) begin
		if (wait_we) begin
			wait_mem[tail_q] <= {cmd_q.weight, cmd_q.id};
		end
		if (wait_re) begin
			wait_rd_q <= wait_mem[head_q];
		end
	end

endmodule

>>> rtl/core/slot_allocator_with_waitlist_top.sv
// Top level of the slot allocator with waitlist.
// Each item yields exactly one result. The front end takes an item whenever
// its two-entry command queue has room, so input and output stall on their
// own. The back end runs one item at a time through a sequencer. A price
// load, an ignored item, a queued or dropped arrival, a failed departure or
// a departure that serves nobody has its result registered in PICK, after
// SCAN; a granted arrival goes on through MUL and ACC (slot search, price
// read, 16x16 multiply, saturating 48-bit add); a departure that hands its
// slot to the waitlist head passes WAITRD first for the waitlist memory
// read. The next item starts in the back end once the previous result has
// been taken or is being taken. slots_in_use is to be written only while
// the block is idle, a rule for the user that the block does not enforce;
// a value of zero or above SLOT_COUNT limits allocation accordingly.
module slot_allocator_with_waitlist_top #(
	parameter int SLOT_COUNT = sawl_pkg::SLOT_COUNT_DEF,
	parameter int WAIT_DEPTH = sawl_pkg::WAIT_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [sawl_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sawl_pkg::MODE_W-1:0]   mode,
	input  logic [sawl_pkg::ID_W-1:0]     requester_id,
	input  logic [sawl_pkg::WEIGHT_W-1:0] requester_weight,
	input  logic [sawl_pkg::SIDX_W-1:0]   slot_index,
	input  logic [sawl_pkg::PRICE_W-1:0]  slot_price,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          granted,
	output logic [sawl_pkg::SIDX_W-1:0]   granted_slot,
	output logic [sawl_pkg::ID_W-1:0]     granted_id,
	output logic [sawl_pkg::CHARGE_W-1:0] charge,
	output logic [sawl_pkg::TOTAL_W-1:0]  total,
	output logic                          queued,
	output logic [1:0]                    status
);
	import sawl_pkg::*;

	logic [CFG_W-1:0] slots_in_use_q;
	qwr_t             q_wr;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	cmd_t             q_cmd;
	result_t          res;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= SLOTS_IN_USE_RST;
		end else if (cfg_wr_en) begin
			slots_in_use_q <= cfg_wr_data;
		end
	end

	sawl_front #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.requester_id    (requester_id),
		.requester_weight(requester_weight),
		.slot_index      (slot_index),
		.slot_price      (slot_price),
		.q_full          (q_full),
		.q_wr            (q_wr)
	);

	sawl_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_wr    (q_wr),
		.q_full  (q_full),
		.pop     (q_pop),
		.rd_valid(q_valid),
		.rd_cmd  (q_cmd)
	);

	sawl_back #(
		.SLOT_COUNT(SLOT_COUNT),
		.WAIT_DEPTH(WAIT_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.slots_in_use(slots_in_use_q),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_res     (res)
	);

	// Result fields
	assign granted      = res.granted;
	assign granted_slot = res.granted_slot;
	assign granted_id   = res.granted_id;
	assign charge       = res.charge;
	assign total        = res.total;
	assign queued       = res.queued;
	assign status       = res.status;

endmodule

>>> rtl/core/sawl_checker.sv
// Port-level checks on the allocator's results, bound to the top level.
module sawl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          granted,
	input logic [sawl_pkg::SIDX_W-1:0]   granted_slot,
	input logic [sawl_pkg::ID_W-1:0]     granted_id,
	input logic [sawl_pkg::CHARGE_W-1:0] charge,
	input logic [sawl_pkg::TOTAL_W-1:0]  total,
	input logic                          queued,
	input logic [1:0]                    status
);
	import sawl_pkg::*;

	logic [TOTAL_W-1:0] last_total_q;
	logic               have_q;

	// Total of the last delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
			have_q       <= 1'b0;
		end else if (out_valid && !out_stall) begin
			last_total_q <= total;
			have_q       <= 1'b1;
		end
	end

	// A charge only comes with a grant
	a_charge_granted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (charge != '0) |-> granted)
		else $error("charge without grant");

	// A grant never goes to requester zero, and never together with queueing
	a_grant_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && granted |-> (granted_id != '0) && !queued
			&& (status == STAT_OK))
		else $error("bad grant result");

	// A flagged item changes nothing
	a_flag_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_OK) |-> !granted && !queued
			&& (charge == '0) && (granted_slot == '0))
		else $error("flagged item has side effects");

	// The running total never falls between delivered items
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && have_q |-> total >= last_total_q)
		else $error("total decreased");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(total) && $stable(charge)
			&& $stable(granted_id))
		else $error("stalled result changed");

endmodule

bind slot_allocator_with_waitlist_top sawl_checker u_sawl_checker (.*);

>>> test/slot_allocator_with_waitlist_top_test.sv
// Self-checking testbench for the slot allocator with waitlist, with a built-in predictor.
`timescale 1ns / 100ps

module slot_allocator_with_waitlist_top_test;
	import sawl_pkg::*;

	localparam int SLOT_COUNT = SLOT_COUNT_DEF;
	localparam int WAIT_DEPTH = WAIT_DEPTH_DEF;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [ID_W-1:0]     id;
		logic [WEIGHT_W-1:0] weight;
		logic [SIDX_W-1:0]   sidx;
		logic [PRICE_W-1:0]  price;
		logic                lazy;
	} slot_req_t;

	typedef struct packed {
		result_t res;
		logic    lazy;
	} owed_t;

	// DUT inputs, all known from time zero
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]    cfg_wr_data = '0;
	logic                in_valid = 1'b0;
	logic [MODE_W-1:0]   mode = '0;
	logic [ID_W-1:0]     requester_id = '0;
	logic [WEIGHT_W-1:0] requester_weight = '0;
	logic [SIDX_W-1:0]   slot_index = '0;
	logic [PRICE_W-1:0]  slot_price = '0;
	logic                out_stall = 1'b0;

	// DUT outputs
	logic                in_stall;
	logic                out_valid;
	logic                granted;
	logic [SIDX_W-1:0]   granted_slot;
	logic [ID_W-1:0]     granted_id;
	logic [CHARGE_W-1:0] charge;
	logic [TOTAL_W-1:0]  total;
	logic                queued;
	logic [1:0]          status;

	// Predictor state
	logic [ID_W-1:0]    seat_holder [SLOT_COUNT];
	logic [PRICE_W-1:0] seat_price [SLOT_COUNT];
	logic [ENTRY_W-1:0] wl_mem [WAIT_DEPTH];
	int                 wl_head, wl_tail, wl_fill;
	logic [TOTAL_W-1:0] run_total;
	logic [CFG_W-1:0]   slot_limit;

	// Stimulus and checking bookkeeping
	slot_req_t item_backlog[$];
	owed_t     owed_results[$];
	slot_req_t on_wire;
	owed_t     due_in, due_out;
	logic      holding;
	int        send_gap;
	int        hold_rx;
	int        mismatch_count;
	int        quiet_cycles;

	slot_allocator_with_waitlist_top #(
		.SLOT_COUNT(SLOT_COUNT),
		.WAIT_DEPTH(WAIT_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.requester_id(requester_id),
		.requester_weight(requester_weight),
		.slot_index(slot_index),
		.slot_price(slot_price),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.granted(granted),
		.granted_slot(granted_slot),
		.granted_id(granted_id),
		.charge(charge),
		.total(total),
		.queued(queued),
		.status(status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hand a slot to a requester and charge price * weight into the saturating total
	function automatic void give_slot(int s, logic [ID_W-1:0] who, logic [WEIGHT_W-1:0] w,
			inout result_t res);
		logic [CHARGE_W-1:0] c;
		logic [TOTAL_W:0]    sum;
		c = CHARGE_W'(seat_price[s]) * CHARGE_W'(w);
		seat_holder[s] = who;
		sum = {1'b0, run_total} + (TOTAL_W + 1)'(c);
		run_total = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
		res.granted = 1'b1;
		res.granted_slot = SIDX_W'(s);
		res.granted_id = who;
		res.charge = c;
	endfunction

	// Apply one item to the predicted state and return the result it should produce
	function automatic result_t allocate_and_charge(slot_req_t r);
		result_t            res;
		int                 usable, at;
		logic               hit;
		logic [ENTRY_W-1:0] e;
		res = '0;
		res.status = STAT_OK;
		usable = (int'(slot_limit) < SLOT_COUNT) ? int'(slot_limit) : SLOT_COUNT;
		hit = 1'b0;
		at = 0;
		case (r.mode)
			MODE_LOAD: begin
				seat_price[r.sidx] = r.price;
			end
			MODE_ARRIVE: begin
				if (r.id != '0) begin
					for (int s = 0; s < usable; s++) begin
						if (!hit && seat_holder[s] == '0) begin
							hit = 1'b1;
							at = s;
						end
					end
					if (hit) begin
						give_slot(at, r.id, r.weight, res);
					end else if (wl_fill >= WAIT_DEPTH) begin
						res.status = STAT_WAIT_FULL;
					end else begin
						wl_mem[wl_tail] = {r.weight, r.id};
						wl_tail = (wl_tail + 1) % WAIT_DEPTH;
						wl_fill++;
						res.queued = 1'b1;
					end
				end
			end
			MODE_DEPART: begin
				// lowest slot holding the id; waitlisted ids do not count
				if (r.id != '0) begin
					for (int s = 0; s < SLOT_COUNT; s++) begin
						if (!hit && seat_holder[s] == r.id) begin
							hit = 1'b1;
							at = s;
						end
					end
				end
				if (!hit) begin
					res.status = STAT_NOT_FOUND;
				end else begin
					seat_holder[at] = '0;
					// a freed slot past the usable count stays empty
					if (wl_fill > 0 && at < usable) begin
						e = wl_mem[wl_head];
						wl_head = (wl_head + 1) % WAIT_DEPTH;
						wl_fill--;
						give_slot(at, e[ID_W-1:0], e[ENTRY_W-1:ID_W], res);
					end
				end
			end
			default: ;
		endcase
		res.total = run_total;
		return res;
	endfunction

	function automatic void log_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
		if (want !== got)
			log_mismatch($sformatf("%s: expected %0h, got %0h", name, want, got));
	endfunction

	function automatic void queue_item(logic [MODE_W-1:0] m, int unsigned who,
			int unsigned w, int unsigned sidx, int unsigned p, logic lazy);
		item_backlog.push_back('{m, ID_W'(who), WEIGHT_W'(w), SIDX_W'(sidx),
			PRICE_W'(p), lazy});
	endfunction

	// Driver: present backlog items, predict each one as it is accepted
	always @(posedge clk) begin
		if (arst_n) begin
			holding = in_valid;
			if (in_valid && !in_stall) begin
				due_in.res = allocate_and_charge(on_wire);
				due_in.lazy = on_wire.lazy;
				owed_results.push_back(due_in);
				holding = 1'b0;
				send_gap = on_wire.lazy ? $urandom_range(0, 10) : 0;
			end
			if (!holding) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (item_backlog.size() != 0) begin
					on_wire = item_backlog.pop_front();
					holding = 1'b1;
					mode <= on_wire.mode;
					requester_id <= on_wire.id;
					requester_weight <= on_wire.weight;
					slot_index <= on_wire.sidx;
					slot_price <= on_wire.price;
				end
			end
			in_valid <= holding;
		end
	end

	// Monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					log_mismatch("result with no item outstanding");
				end else begin
					due_out = owed_results.pop_front();
					check_field("granted", 48'(due_out.res.granted), 48'(granted));
					check_field("granted_slot", 48'(due_out.res.granted_slot),
						48'(granted_slot));
					check_field("granted_id", 48'(due_out.res.granted_id), 48'(granted_id));
					check_field("charge", 48'(due_out.res.charge), 48'(charge));
					check_field("total", due_out.res.total, total);
					check_field("queued", 48'(due_out.res.queued), 48'(queued));
					check_field("status", 48'(due_out.res.status), 48'(status));
					hold_rx = due_out.lazy ? $urandom_range(0, 10) : 0;
				end
			end else if (hold_rx > 0) begin
				hold_rx--;
			end
			out_stall <= (hold_rx > 0);
		end
	end

	// Watchdog: nothing moving on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", quiet_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Wait until every item is in and every result is out, then let the pipe drain
	task automatic settle();
		do @(negedge clk);
		while (item_backlog.size() != 0 || owed_results.size() != 0 || in_valid);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_slot_limit(int v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CFG_W'(v);
		slot_limit = CFG_W'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random traffic; ids mostly from a small pool so departures find holders
	task automatic add_random(int n, int arrive_pct);
		int                pick, k, who;
		logic              lazy;
		logic [MODE_W-1:0] m;
		lazy = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (i % 25 == 0)
				lazy = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 8)
				m = MODE_LOAD;
			else if (pick < 8 + arrive_pct)
				m = MODE_ARRIVE;
			else if (pick < 96)
				m = MODE_DEPART;
			else
				m = MODE_UNUSED;
			k = $urandom_range(0, 39);
			if (k == 0)
				who = 0;
			else if (k < 6)
				who = $urandom_range(1, 2047);
			else if (k < 22)
				who = k - 5;
			else
				who = k + 78;
			queue_item(m, who, $urandom, $urandom, $urandom, lazy);
		end
	endtask

	initial begin
		slot_limit = SLOTS_IN_USE_RST;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			seat_holder[s] = '0;
			seat_price[s] = '0;
		end
		wl_head = 0;
		wl_tail = 0;
		wl_fill = 0;
		run_total = '0;
		mismatch_count = 0;
		quiet_cycles = 0;
		send_gap = 0;
		hold_rx = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two usable slots: ignored items, repeat arrival, waitlist handoff
		set_slot_limit(2);
		queue_item(MODE_LOAD, $urandom, $urandom, 0, 'hFFFF, 1'b1);
		queue_item(MODE_LOAD, $urandom, $urandom, 1, 1, 1'b1);
		queue_item(MODE_ARRIVE, 0, 5, $urandom, $urandom, 1'b1);
		queue_item(MODE_UNUSED, 2047, 'hFFFF, 15, 'hFFFF, 1'b1);
		queue_item(MODE_DEPART, 0, $urandom, $urandom, $urandom, 1'b1);
		queue_item(MODE_ARRIVE, 2047, 'hFFFF, $urandom, $urandom, 1'b1);
		queue_item(MODE_ARRIVE, 2047, 0, $urandom, $urandom, 1'b1);
		queue_item(MODE_ARRIVE, 5, 3, $urandom, $urandom, 1'b1);
		queue_item(MODE_ARRIVE, 6, 7, $urandom, $urandom, 1'b1);
		queue_item(MODE_DEPART, 5, $urandom, $urandom, $urandom, 1'b1);
		queue_item(MODE_DEPART, 99, $urandom, $urandom, $urandom, 1'b1);
		queue_item(MODE_DEPART, 2047, $urandom, $urandom, $urandom, 1'b1);
		queue_item(MODE_DEPART, 2047, $urandom, $urandom, $urandom, 1'b1);
		settle();

		// No usable slot: everything waits, waitlist overflows, freed slots stay empty
		set_slot_limit(0);
		for (int i = 0; i < WAIT_DEPTH + 2; i++)
			queue_item(MODE_ARRIVE, 100 + i, $urandom, $urandom, $urandom, 1'b1);
		queue_item(MODE_DEPART, 5, $urandom, $urandom, $urandom, 1'b1);
		queue_item(MODE_DEPART, 6, $urandom, $urandom, $urandom, 1'b1);
		settle();

		// Count above the slot range; load the remaining prices first
		set_slot_limit(31);
		for (int s = 2; s < SLOT_COUNT; s++)
			queue_item(MODE_LOAD, $urandom, $urandom, s, $urandom, 1'b1);
		add_random(100, 60);
		add_random(100, 40);
		settle();

		set_slot_limit(1);
		add_random(120, 45);
		settle();

		set_slot_limit(16);
		add_random(120, 50);
		settle();

		set_slot_limit($urandom_range(2, 15));
		add_random(110, 50);
		settle();

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
